// ===== rtl/fgn_pkg.sv =====
// ---------------------------------------------------------------------------
// Fractal gradient noise height package
// Shared types and fixed constants for the terrain height pipeline.
// ---------------------------------------------------------------------------
package fgn_pkg;

	localparam int ADDR_W = 3;

	localparam logic REG_NOISE_SCALE  = 1'b0;
	localparam logic REG_HEIGHT_SCALE = 1'b1;

	localparam logic [23:0] NOISE_SCALE_RST  = 24'd8389;
	localparam logic [15:0] HEIGHT_SCALE_RST = 16'd1000;

	localparam int OCT_MULT0 = 1;
	localparam int OCT_MULT1 = 5;
	localparam int OCT_MULT2 = 12;

	// Division by 100 through a reciprocal of 2^34 / 100.
	localparam logic [27:0] RECIP_100   = 28'd171798691;
	localparam logic [33:0] DIV_OFFSET  = 34'd6710886400;
	localparam logic [28:0] DIV_OFFSET_Q = 29'd67108864;

	typedef struct packed {
		logic [23:0] noise_scale;
		logic [15:0] height_scale;
	} cfg_t;

endpackage

// ===== rtl/fgn_cfg.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the noise scale and the height scale.
// ---------------------------------------------------------------------------
module fgn_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fgn_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output fgn_pkg::cfg_t             cfg
);
	import fgn_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_scale  <= NOISE_SCALE_RST;
			cfg_q.height_scale <= HEIGHT_SCALE_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_NOISE_SCALE:  cfg_q.noise_scale  <= pwdata[23:0];
				REG_HEIGHT_SCALE: cfg_q.height_scale <= pwdata[15:0];
				default:          cfg_q.noise_scale  <= cfg_q.noise_scale;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NOISE_SCALE:  prdata = {8'd0, cfg_q.noise_scale};
			REG_HEIGHT_SCALE: prdata = {16'd0, cfg_q.height_scale};
			default:          prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

// ===== rtl/fgn_octave.sv =====
// ---------------------------------------------------------------------------
// Noise octave lane
// Lattice split, quintic fade, corner gradients and bilinear blend for one
// octave, stages two through eleven.
// ---------------------------------------------------------------------------
module fgn_octave #(
	parameter int FRAC_BITS = 16,
	parameter int MULT      = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vin,
	input  logic [31:0]              px,
	input  logic [31:0]              py,
	output logic                     vout,
	output logic signed [FRAC_BITS+3:0] noise
);
	localparam int F  = FRAC_BITS;
	localparam int CW = F + 3;
	localparam int DW = F + 4;
	localparam int PW = DW + F + 2;
	localparam int NW = F + 4;
	localparam int HW = NW + 1;
	localparam int VW = HW + F + 2;
	localparam int FW = F + 6;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	function automatic logic signed [CW-1:0] corner(input logic [1:0] sel,
			input logic signed [CW-1:0] dx, input logic signed [CW-1:0] dy);
		logic signed [CW-1:0] u;
		logic signed [CW-1:0] v;
		u = sel[1] ? dy : dx;
		v = sel[1] ? dx : dy;
		corner = (sel[0] ? -u : u) + (sel[1] ? -v : v);
	endfunction

	logic [10:2] v_q;

	// Stage 2: lattice split.
	logic [31:0]  mx, my;
	logic [1:0]   xi_s2, yi_s2;
	logic [F-1:0] xf_s2, yf_s2;

	assign mx = 32'(px * 32'(MULT));
	assign my = 32'(py * 32'(MULT));

	always_ff @(posedge clk) begin
		if (en) begin
			xi_s2 <= mx[25:24];
			yi_s2 <= my[25:24];
			xf_s2 <= mx[23:24-F];
			yf_s2 <= my[23:24-F];
		end
	end

	// Stage 3: corner gradients and t squared.
	logic [1:0] ha, hb, haa, hab, hba, hbb;
	logic signed [CW-1:0] dx0, dx1, dy0, dy1;
	logic [2*F-1:0] x2m, y2m;
	logic signed [CW-1:0] caa_s3, cab_s3, cba_s3, cbb_s3;
	logic [F-1:0] xt_s3, yt_s3, x2_s3, y2_s3;

	assign ha  = xi_s2 + yi_s2;
	assign hb  = ha + 2'd1;
	assign haa = ha + xi_s2;
	assign hab = ha + yi_s2;
	assign hba = hb + xi_s2;
	assign hbb = hb + yi_s2;
	assign dx0 = $signed(CW'(xf_s2));
	assign dy0 = $signed(CW'(yf_s2));
	assign dx1 = dx0 - $signed(CW'(ONE));
	assign dy1 = dy0 - $signed(CW'(ONE));
	assign x2m = xf_s2 * xf_s2;
	assign y2m = yf_s2 * yf_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			caa_s3 <= corner(haa, dx0, dy0);
			cba_s3 <= corner(hba, dx1, dy0);
			cab_s3 <= corner(hab, dx0, dy1);
			cbb_s3 <= corner(hbb, dx1, dy1);
			xt_s3  <= xf_s2;
			yt_s3  <= yf_s2;
			x2_s3  <= x2m[2*F-1:F];
			y2_s3  <= y2m[2*F-1:F];
		end
	end

	// Stages 4 to 6: t cubed, fourth and fifth powers.
	logic [2*F-1:0] x3m, y3m, x4m, y4m, x5m, y5m;
	logic signed [CW-1:0] caa_s4, cab_s4, cba_s4, cbb_s4;
	logic signed [CW-1:0] caa_s5, cab_s5, cba_s5, cbb_s5;
	logic signed [CW-1:0] caa_s6, cab_s6, cba_s6, cbb_s6;
	logic [F-1:0] xt_s4, yt_s4, x3_s4, y3_s4;
	logic [F-1:0] xt_s5, yt_s5, x3_s5, y3_s5, x4_s5, y4_s5;
	logic [F-1:0] x3_s6, y3_s6, x4_s6, y4_s6, x5_s6, y5_s6;

	assign x3m = x2_s3 * xt_s3;
	assign y3m = y2_s3 * yt_s3;
	assign x4m = x3_s4 * xt_s4;
	assign y4m = y3_s4 * yt_s4;
	assign x5m = x4_s5 * xt_s5;
	assign y5m = y4_s5 * yt_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			caa_s4 <= caa_s3; cab_s4 <= cab_s3; cba_s4 <= cba_s3; cbb_s4 <= cbb_s3;
			xt_s4  <= xt_s3;
			yt_s4  <= yt_s3;
			x3_s4  <= x3m[2*F-1:F];
			y3_s4  <= y3m[2*F-1:F];
			caa_s5 <= caa_s4; cab_s5 <= cab_s4; cba_s5 <= cba_s4; cbb_s5 <= cbb_s4;
			xt_s5  <= xt_s4;
			yt_s5  <= yt_s4;
			x3_s5  <= x3_s4;
			y3_s5  <= y3_s4;
			x4_s5  <= x4m[2*F-1:F];
			y4_s5  <= y4m[2*F-1:F];
			caa_s6 <= caa_s5; cab_s6 <= cab_s5; cba_s6 <= cba_s5; cbb_s6 <= cbb_s5;
			x3_s6  <= x3_s5;
			y3_s6  <= y3_s5;
			x4_s6  <= x4_s5;
			y4_s6  <= y4_s5;
			x5_s6  <= x5m[2*F-1:F];
			y5_s6  <= y5m[2*F-1:F];
		end
	end

	// Stage 7: fade polynomial with clamp.
	function automatic logic [F:0] fade(input logic [F-1:0] t3, input logic [F-1:0] t4,
			input logic [F-1:0] t5);
		logic signed [FW-1:0] e3;
		logic signed [FW-1:0] e4;
		logic signed [FW-1:0] e5;
		logic signed [FW-1:0] fs;
		e3 = $signed(FW'(t3));
		e4 = $signed(FW'(t4));
		e5 = $signed(FW'(t5));
		fs = FW'(e5 * 6 - e4 * 15 + e3 * 10);
		if (fs < 0) begin
			fade = '0;
		end else if (fs > $signed(FW'(ONE))) begin
			fade = ONE;
		end else begin
			fade = fs[F:0];
		end
	endfunction

	logic signed [CW-1:0] caa_s7, cab_s7, cba_s7, cbb_s7;
	logic [F:0] u_s7, w_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			caa_s7 <= caa_s6; cab_s7 <= cab_s6; cba_s7 <= cba_s6; cbb_s7 <= cbb_s6;
			u_s7   <= fade(x3_s6, x4_s6, x5_s6);
			w_s7   <= fade(y3_s6, y4_s6, y5_s6);
		end
	end

	// Stages 8 and 9: blend along x.
	logic signed [DW-1:0] dlo, dhi;
	logic signed [PW-1:0] plo_s8, phi_s8;
	logic signed [CW-1:0] caa_s8, cab_s8;
	logic [F:0] w_s8, w_s9;
	logic signed [NW-1:0] lo_s9, hi_s9;
	logic signed [PW-1:0] slo, shi;

	assign dlo = DW'(cba_s7) - DW'(caa_s7);
	assign dhi = DW'(cbb_s7) - DW'(cab_s7);
	assign slo = plo_s8 >>> F;
	assign shi = phi_s8 >>> F;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s8 <= PW'(dlo * $signed({1'b0, u_s7}));
			phi_s8 <= PW'(dhi * $signed({1'b0, u_s7}));
			caa_s8 <= caa_s7;
			cab_s8 <= cab_s7;
			w_s8   <= w_s7;
			lo_s9  <= NW'(NW'(caa_s8) + NW'(slo));
			hi_s9  <= NW'(NW'(cab_s8) + NW'(shi));
			w_s9   <= w_s8;
		end
	end

	// Stages 10 and 11: blend along y.
	logic signed [HW-1:0] dv;
	logic signed [VW-1:0] pv_s10, sv;
	logic signed [NW-1:0] lo_s10, n_s11;

	assign dv = HW'(hi_s9) - HW'(lo_s9);
	assign sv = pv_s10 >>> F;

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s10 <= VW'(dv * $signed({1'b0, w_s9}));
			lo_s10 <= lo_s9;
			n_s11  <= NW'(NW'(lo_s10) + NW'(sv));
		end
	end

	logic v_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_q   <= {v_q[9:2], vin};
			v_s11 <= v_q[10];
		end
	end

	assign vout  = v_s11;
	assign noise = n_s11;

endmodule

// ===== rtl/fgn_out.sv =====
// ---------------------------------------------------------------------------
// Height combiner
// Weights and sums the octaves, scales by 256 * height scale, divides by
// 100 * 2^FRAC_BITS with floor rounding, stages twelve through seventeen.
// ---------------------------------------------------------------------------
module fgn_out #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vin,
	input  logic signed [FRAC_BITS+3:0] n0,
	input  logic signed [FRAC_BITS+3:0] n1,
	input  logic signed [FRAC_BITS+3:0] n2,
	input  logic [15:0]                 height_scale,
	output logic                        vout,
	output logic signed [31:0]          height
);
	import fgn_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int AW = F + 9;
	localparam int MW = AW + 17;
	localparam int EW = MW + 8;

	logic signed [AW-1:0] a0, a1, a2, acc_s12;
	logic signed [MW-1:0] prod_s13;
	logic signed [EW-1:0] ext, shd;
	logic [33:0] wb_s14, wb_s15, wb_s16;
	logic [44:0] pl_s15, ph_s15;
	logic [62:0] rsum;
	logic [28:0] q0_s16, qf;
	logic [33:0] rem;
	logic signed [28:0] qs;
	logic signed [31:0] h_s17;
	logic [16:12] v_q;
	logic v_s17;

	assign a0   = AW'(n0);
	assign a1   = AW'(n1);
	assign a2   = AW'(n2);
	assign ext  = {prod_s13, 8'd0};
	assign shd  = ext >>> F;
	assign rsum = {ph_s15, 17'd0} + 63'(pl_s15);
	assign rem  = wb_s16 - 34'(q0_s16 * 29'd100);
	assign qf   = q0_s16 + ((rem >= 34'd100) ? 29'd1 : 29'd0);
	assign qs   = $signed(qf - DIV_OFFSET_Q);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s12  <= AW'(a0 * 20 + a1 * 8 + a2 * 3);
			prod_s13 <= MW'(acc_s12 * $signed({1'b0, height_scale}));
			wb_s14   <= 34'(shd) + DIV_OFFSET;
			pl_s15   <= wb_s14[16:0] * RECIP_100;
			ph_s15   <= wb_s14[33:17] * RECIP_100;
			wb_s15   <= wb_s14;
			q0_s16   <= rsum[62:34];
			wb_s16   <= wb_s15;
			h_s17    <= 32'(qs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= '0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_q   <= {v_q[15:12], vin};
			v_s17 <= v_q[16];
		end
	end

	assign vout   = v_s17;
	assign height = h_s17;

endmodule

// ===== rtl/fractal_gradient_noise_height_top.sv =====
// ---------------------------------------------------------------------------
// Fractal gradient noise height
// Throughput is one word per cycle; the whole pipeline holds while the output
// word is stalled.
// Reset clears the valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
module fractal_gradient_noise_height_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fgn_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [31:0]         x_pos,
	input  logic signed [31:0]         y_pos,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         height
);
	import fgn_pkg::*;

	localparam int NW = FRAC_BITS + 4;

	cfg_t cfg;
	logic adv;
	logic v_s1;
	logic [31:0] px_s1, py_s1;
	logic [55:0] mx, my;
	logic vo0, vo1, vo2;
	logic signed [NW-1:0] n0, n1, n2;

	fgn_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	assign mx = $unsigned(x_pos) * cfg.noise_scale;
	assign my = $unsigned(y_pos) * cfg.noise_scale;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= mx[31:0];
			py_s1 <= my[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	fgn_octave #(.FRAC_BITS(FRAC_BITS), .MULT(OCT_MULT0)) u_oct0 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s1), .px(px_s1), .py(py_s1),
		.vout(vo0), .noise(n0)
	);

	fgn_octave #(.FRAC_BITS(FRAC_BITS), .MULT(OCT_MULT1)) u_oct1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s1), .px(px_s1), .py(py_s1),
		.vout(vo1), .noise(n1)
	);

	fgn_octave #(.FRAC_BITS(FRAC_BITS), .MULT(OCT_MULT2)) u_oct2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_s1), .px(px_s1), .py(py_s1),
		.vout(vo2), .noise(n2)
	);

	fgn_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(vo0 & vo1 & vo2),
		.n0(n0), .n1(n1), .n2(n2), .height_scale(cfg.height_scale),
		.vout(out_valid), .height(height)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fractal gradient noise height testbench
// Drives coordinate words with random gaps and output stalls, programs both
// scale registers through the APB port between phases, and checks every
// height word against a fixed-point model of the three-octave noise sum.
// ---------------------------------------------------------------------------
module tb;
	import fgn_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 17;
	localparam logic [ADDR_W-1:0] ADDR_NOISE = ADDR_W'(4 * REG_NOISE_SCALE);
	localparam logic [ADDR_W-1:0] ADDR_HEIGHT = ADDR_W'(4 * REG_HEIGHT_SCALE);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		bit          known;
		logic [31:0] h;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [31:0]       x_pos = '0;
	logic signed [31:0]       y_pos = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [31:0]       height;

	logic [23:0]  model_noise_scale;
	logic [15:0]  model_height_scale;
	logic [31:0]  expected_heights[$];
	int           errors = 0;
	bit           stall_quiet = 1'b0;

	fractal_gradient_noise_height_top dut (.*);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fade(longint t);
		longint t2, t3, t4, t5, f;
		t2 = (t * t) >>> FB;
		t3 = (t2 * t) >>> FB;
		t4 = (t3 * t) >>> FB;
		t5 = (t4 * t) >>> FB;
		f = 6 * t5 - 15 * t4 + 10 * t3;
		if (f < 0) f = 0;
		if (f > (64'sd1 <<< FB)) f = 64'sd1 <<< FB;
		return f;
	endfunction

	function automatic longint gradient(logic [7:0] h, longint dx, longint dy);
		longint u, v;
		u = (h[1:0] < 2) ? dx : dy;
		v = (h[1:0] < 2) ? dy : dx;
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic longint mix(longint a, longint b, longint t);
		return a + floor_shift((b - a) * t, FB);
	endfunction

	function automatic longint octave_noise(longint x, longint y, longint mult);
		longint px, py, xf, yf, u, v, one, lo, hi;
		logic [7:0] xi, yi, a, b;
		one = 64'sd1 <<< FB;
		px = x * longint'(model_noise_scale) * mult;
		py = y * longint'(model_noise_scale) * mult;
		xi = 8'(floor_shift(px, 24));
		yi = 8'(floor_shift(py, 24));
		xf = longint'(px[23:0]) >>> (24 - FB);
		yf = longint'(py[23:0]) >>> (24 - FB);
		u = fade(xf);
		v = fade(yf);
		a = xi + yi;
		b = a + 8'd1;
		lo = mix(gradient(a + xi, xf, yf), gradient(b + xi, xf - one, yf), u);
		hi = mix(gradient(a + yi, xf, yf - one), gradient(b + yi, xf - one, yf - one), u);
		return mix(lo, hi, v);
	endfunction

	function automatic logic [31:0] terrain_height(logic signed [31:0] x, logic signed [31:0] y);
		longint acc, total, d, q;
		acc = octave_noise(x, y, OCT_MULT0) * 20 + octave_noise(x, y, OCT_MULT1) * 8
			+ octave_noise(x, y, OCT_MULT2) * 3;
		total = acc * longint'(model_height_scale) * 256;
		d = 64'sd100 <<< FB;
		q = total / d;
		if (total < 0 && q * d != total) q--;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_NOISE) model_noise_scale = data[23:0];
		else if (addr == ADDR_HEIGHT) model_height_scale = data[15:0];
	endtask

	task automatic drain();
		while (expected_heights.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic int gap_length();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	task automatic send_word(logic [31:0] x, logic [31:0] y, bit known, logic [31:0] h);
		logic [31:0] model_h;
		model_h = terrain_height(x, y);
		if (known && model_h !== h) begin
			$error("height: table expects %0d, model gives %0d", $signed(h), $signed(model_h));
			errors++;
		end
		in_valid <= 1'b1;
		x_pos <= x;
		y_pos <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_heights.push_back(model_h);
	endtask

	task automatic send_random(int count, bit gaps);
		int g;
		logic [31:0] x, y;
		for (int i = 0; i < count; i++) begin
			g = gaps ? gap_length() : 0;
			if (g != 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			case ($urandom_range(3))
				0: begin
					x = $urandom;
					y = $urandom;
				end
				1: begin
					x = 32'($signed($urandom_range(4000)) - 2000);
					y = 32'($signed($urandom_range(4000)) - 2000);
				end
				2: begin
					x = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255)
						: 32'h8000_0000 + $urandom_range(255);
					y = $urandom;
				end
				default: begin
					x = 32'($signed($urandom_range(2000000)) - 1000000);
					y = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
				end
			endcase
			send_word(x, y, 1'b0, '0);
		end
		in_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_heights.size() == 0) begin
				$error("height: word %0d arrived with nothing expected", height);
				errors++;
			end else begin
				if (height !== expected_heights[0]) begin
					$error("height: expected %0d, got %0d",
						$signed(expected_heights[0]), height);
					errors++;
				end
				void'(expected_heights.pop_front());
			end
		end
	end

	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (stall_quiet) begin
				out_stall <= 1'b0;
			end else begin
				g = gap_length();
				out_stall <= (g != 0);
				repeat (g > 1 ? g - 1 : 0) @(posedge clk);
			end
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		logic [23:0] noise_settings[5];
		logic [15:0] height_settings[5];
		model_noise_scale = NOISE_SCALE_RST;
		model_height_scale = HEIGHT_SCALE_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{32'd0, 32'd0, 1'b1, 32'd0},
			'{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
			'{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
			'{32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
			'{32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
			'{32'hffff_ffff, 32'd1, 1'b0, '0},
			'{32'd1000, 32'd2000, 1'b0, '0},
			'{32'd1999, 32'hffff_f831, 1'b0, '0},
			'{32'd123456, 32'd654321, 1'b0, '0},
			'{32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
			'{32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
			'{32'd2000, 32'd0, 1'b0, '0},
			'{32'd0, 32'd2000, 1'b0, '0}
		};
		foreach (rows[i]) send_word(rows[i].x, rows[i].y, rows[i].known, rows[i].h);
		in_valid <= 1'b0;
		drain();

		apb_write(ADDR_NOISE, 32'd0);
		send_word(32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'd0);
		send_word(32'd12345, 32'hdead_beef, 1'b1, 32'd0);
		in_valid <= 1'b0;
		drain();

		noise_settings = '{24'hff_ffff, 24'd8389, 24'd1, 24'h80_0000, 24'd0};
		height_settings = '{16'hffff, 16'd1000, 16'd0, 16'd1, 16'd37};
		for (int p = 0; p < 5; p++) begin
			apb_write(ADDR_NOISE, {8'hff, noise_settings[p]});
			apb_write(ADDR_HEIGHT, {16'hffff, height_settings[p]});
			if (p == 4) apb_write(ADDR_NOISE, 32'($urandom_range(24'hff_ffff)));
			stall_quiet = (p == 2);
			send_random(p == 1 ? 1000 : 200, p != 2);
			drain();
		end
		stall_quiet = 1'b0;

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
